>>> hw/rtl/flt_pkg.sv
package flt_pkg;

  // Table geometry
  localparam int BUCKETS  = 1024;
  localparam int WAYS     = 4;
  localparam int SLOTS    = BUCKETS * WAYS;
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int WAY_W    = $clog2(WAYS);
  localparam int SLOT_W   = BUCKET_W + WAY_W;
  localparam int RANK_W   = WAY_W;
  localparam int CNT_W    = 13;
  localparam int NWAY_W   = WAY_W + 1;

  typedef logic [BUCKET_W-1:0] bucket_t;
  typedef logic [WAY_W-1:0]    way_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [NWAY_W-1:0]   nway_t;

  // Constants
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [12:0] RESET_MAX_FLOWS = 13'd4096;
  localparam logic [7:0]  RESET_IDLE      = 8'd30;
  localparam logic [7:0]  RESET_SWEEP     = 8'd1;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_FLOWS      = 2'd0;
  localparam logic [1:0] REG_IDLE_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_SWEEP_INTERVAL = 2'd2;

  typedef enum logic [1:0] {
    OP_PKT     = 2'd0,
    OP_DEFER   = 2'd1,
    OP_DEL_NOW = 2'd2,
    OP_RSVD    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RES_FOUND   = 2'd0,
    RES_CREATED = 2'd1,
    RES_REFUSED = 2'd2,
    RES_DELETED = 2'd3
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEL_RD,
    S_DEL_WR,
    S_PK_RD,
    S_PK_EV,
    S_PK_WR,
    S_SW_RD,
    S_SW_WR,
    S_DONE
  } state_t;

  // One way of a bucket
  typedef struct packed {
    logic        valid;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [7:0]  proto;
    logic        reset_seen;
    logic [31:0] last_fwd;
    logic [31:0] last_rev;
    rank_t       recency;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic del_rd;
    logic del_wr;
    logic pk_rd;
    logic pk_ev;
    logic pk_wr;
    logic sw_rd;
    logic sw_wr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    pend_valid;
    logic    walk_last;
    logic    sweep_due;
    logic    refuse;
  } sts_t;

endpackage

>>> hw/rtl/flow_table_lookup_insert.sv
// Bucketed IPv4 five-tuple flow table with move-to-front ways and idle expiry.
// After reset the block clears its 1024 buckets, one a cycle, with busy high until
// the last is done. An item is taken when start is high and busy is low; its single
// result beat appears on done for one cycle, which the receiver cannot stall. Every
// bucket access reads and then writes the whole row, through one write port and one
// registered read port. A deferred delete or reserved opcode gives its beat in the
// cycle after acceptance; an immediate delete reads and writes its bucket; a packet
// reads, evaluates and writes its bucket, after any pending deferred delete and
// before any due expiry sweep of all buckets. busy drops the cycle after done.
module flow_table_lookup_insert (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [9:0]  bucket_index,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0]  protocol,
  input  logic        syn,
  input  logic        rst_req,
  input  logic [31:0] now_seconds,
  input  logic [11:0] slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [11:0] flow_slot,
  output logic        direction,
  output logic [12:0] expired_count
);

  flt_pkg::cmd_t cmd;
  flt_pkg::sts_t sts;

  // Registers accept a write on any cycle.
  assign cfg_ready = 1'b1;

  flt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  flt_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (opcode),
    .bucket_index  (bucket_index),
    .src_addr      (src_addr),
    .dst_addr      (dst_addr),
    .src_port      (src_port),
    .dst_port      (dst_port),
    .protocol      (protocol),
    .syn           (syn),
    .rst_req       (rst_req),
    .now_seconds   (now_seconds),
    .slot          (slot),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .flow_slot     (flow_slot),
    .direction     (direction),
    .expired_count (expired_count)
  );

endmodule

>>> hw/rtl/flt_ram.sv
module flt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/flt_ctrl.sv
module flt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    opcode,
  input  flt_pkg::sts_t sts,
  output flt_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);

  flt_pkg::state_t state;
  flt_pkg::state_t state_next;

  // State register; reset begins the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      flt_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.walk_last) begin
          state_next = flt_pkg::S_IDLE;
        end
      end
      flt_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (flt_pkg::opcode_t'(opcode))
            flt_pkg::OP_PKT: begin
              state_next = sts.pend_valid ? flt_pkg::S_DEL_RD : flt_pkg::S_PK_RD;
            end
            flt_pkg::OP_DEL_NOW: state_next = flt_pkg::S_DEL_RD;
            default:             state_next = flt_pkg::S_DONE;
          endcase
        end
      end
      flt_pkg::S_DEL_RD: begin
        cmd.del_rd = 1'b1;
        state_next = flt_pkg::S_DEL_WR;
      end
      flt_pkg::S_DEL_WR: begin
        cmd.del_wr = 1'b1;
        state_next = (sts.op == flt_pkg::OP_DEL_NOW) ? flt_pkg::S_DONE : flt_pkg::S_PK_RD;
      end
      flt_pkg::S_PK_RD: begin
        cmd.pk_rd  = 1'b1;
        state_next = flt_pkg::S_PK_EV;
      end
      flt_pkg::S_PK_EV: begin
        cmd.pk_ev  = 1'b1;
        state_next = flt_pkg::S_PK_WR;
      end
      flt_pkg::S_PK_WR: begin
        cmd.pk_wr = 1'b1;
        if (!sts.refuse && sts.sweep_due) begin
          state_next = flt_pkg::S_SW_RD;
        end else begin
          state_next = flt_pkg::S_DONE;
        end
      end
      flt_pkg::S_SW_RD: begin
        cmd.sw_rd  = 1'b1;
        state_next = flt_pkg::S_SW_WR;
      end
      flt_pkg::S_SW_WR: begin
        cmd.sw_wr  = 1'b1;
        state_next = sts.walk_last ? flt_pkg::S_DONE : flt_pkg::S_SW_RD;
      end
      flt_pkg::S_DONE: begin
        state_next = flt_pkg::S_IDLE;
      end
      default: begin
        state_next = flt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != flt_pkg::S_IDLE);
  assign done = (state == flt_pkg::S_DONE);

  // The result strobe lasts a single cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");

  // An accepted item always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

endmodule

>>> hw/rtl/flt_dpath.sv
module flt_dpath (
  input  logic          clk,
  input  logic          rst,
  input  flt_pkg::cmd_t cmd,
  output flt_pkg::sts_t sts,
  input  logic [1:0]    opcode,
  input  logic [9:0]    bucket_index,
  input  logic [31:0]   src_addr,
  input  logic [31:0]   dst_addr,
  input  logic [15:0]   src_port,
  input  logic [15:0]   dst_port,
  input  logic [7:0]    protocol,
  input  logic          syn,
  input  logic          rst_req,
  input  logic [31:0]   now_seconds,
  input  logic [11:0]   slot,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_data,
  output logic [1:0]    status,
  output logic [11:0]   flow_slot,
  output logic          direction,
  output logic [12:0]   expired_count
);

  // Configuration registers
  logic [12:0] max_flows;
  logic [7:0]  idle_timeout;
  logic [7:0]  sweep_interval;

  // Captured item
  flt_pkg::opcode_t op_q;
  flt_pkg::bucket_t bucket_q;
  logic [31:0]      sa_q;
  logic [31:0]      da_q;
  logic [15:0]      sp_q;
  logic [15:0]      dp_q;
  logic [7:0]       proto_q;
  logic             syn_q;
  logic             rstf_q;
  logic [31:0]      now_q;

  // Table-wide state
  flt_pkg::cnt_t    active_count;
  logic [31:0]      last_sweep;
  logic             pend_valid;
  flt_pkg::slot_t   pend_slot;
  flt_pkg::slot_t   del_slot;
  flt_pkg::bucket_t walk_idx;

  // Lookup evaluation
  logic             ev_hit;
  logic             ev_recreate;
  logic             ev_refuse;
  flt_pkg::way_t    ev_found;
  flt_pkg::way_t    ev_free;
  flt_pkg::row_t    row_q;

  // Result registers
  flt_pkg::result_t res_status;
  flt_pkg::slot_t   res_slot;
  logic             res_dir;
  flt_pkg::cnt_t    res_expired;

  // Bucket memory
  logic                     ram_we;
  flt_pkg::bucket_t         ram_waddr;
  flt_pkg::row_t            ram_wrow;
  logic                     ram_re;
  flt_pkg::bucket_t         ram_raddr;
  logic [flt_pkg::ROW_W-1:0] ram_rdata;
  flt_pkg::row_t            rd_row;

  flt_ram #(
    .WIDTH (flt_pkg::ROW_W),
    .DEPTH (flt_pkg::BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrow),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_row = flt_pkg::row_t'(ram_rdata);

  // Delete of one slot, on the row just read.
  flt_pkg::way_t del_way;
  logic          del_hit;
  flt_pkg::row_t del_row;

  always_comb begin
    del_way = del_slot[flt_pkg::WAY_W-1:0];
    del_hit = rd_row[del_way].valid;
    del_row = rd_row;
    for (int w = 0; w < flt_pkg::WAYS; w++) begin
      if (flt_pkg::way_t'(w) == del_way) begin
        del_row[w].valid = 1'b0;
      end else if (rd_row[w].valid && rd_row[w].recency > rd_row[del_way].recency) begin
        del_row[w].recency = rd_row[w].recency - flt_pkg::rank_t'(1);
      end
    end
  end

  // Tuple match in either direction, free way search.
  logic          m_hit;
  flt_pkg::way_t m_found;
  logic          m_has_free;
  flt_pkg::way_t m_free;
  logic          m_recreate;
  logic          m_hit_eff;
  flt_pkg::cnt_t m_active;
  logic          m_refuse;

  always_comb begin
    logic        fwd;
    logic        rev;
    logic        match;
    m_hit      = 1'b0;
    m_found    = '0;
    m_has_free = 1'b0;
    m_free     = '0;
    for (int w = 0; w < flt_pkg::WAYS; w++) begin
      fwd   = (rd_row[w].src_addr == sa_q) && (rd_row[w].dst_addr == da_q) &&
              (rd_row[w].ports == {sp_q, dp_q});
      rev   = (rd_row[w].src_addr == da_q) && (rd_row[w].dst_addr == sa_q) &&
              (rd_row[w].ports == {dp_q, sp_q});
      match = rd_row[w].valid && (rd_row[w].proto == proto_q) && (fwd || rev);
      if (!rd_row[w].valid && !m_has_free) begin
        m_has_free = 1'b1;
        m_free     = flt_pkg::way_t'(w);
      end
      if (match && (!m_hit || rd_row[w].recency < rd_row[m_found].recency)) begin
        m_hit   = 1'b1;
        m_found = flt_pkg::way_t'(w);
      end
    end
    m_recreate = m_hit && (proto_q == flt_pkg::PROTO_TCP) &&
                 rd_row[m_found].reset_seen && syn_q;
    m_hit_eff  = m_hit && !m_recreate;
    if (m_recreate && (!m_has_free || m_found < m_free)) begin
      m_free = m_found;
    end
    if (m_recreate) begin
      m_has_free = 1'b1;
    end
    m_active = active_count - flt_pkg::cnt_t'(m_recreate);
    m_refuse = !m_hit_eff && ((m_active >= max_flows) || !m_has_free);
  end

  // New bucket row for a packet: optional recreate drop, then create or move to front.
  flt_pkg::row_t drop_row;
  flt_pkg::row_t pk_row;
  flt_pkg::way_t pk_way;
  logic          pk_dir;

  always_comb begin
    flt_pkg::rank_t rf;
    flt_pkg::rank_t rt;
    rf       = row_q[ev_found].recency;
    drop_row = row_q;
    if (ev_recreate) begin
      for (int w = 0; w < flt_pkg::WAYS; w++) begin
        if (flt_pkg::way_t'(w) == ev_found) begin
          drop_row[w].valid = 1'b0;
        end else if (row_q[w].valid && row_q[w].recency > rf) begin
          drop_row[w].recency = row_q[w].recency - flt_pkg::rank_t'(1);
        end
      end
    end
    pk_way = ev_hit ? ev_found : ev_free;
    pk_row = drop_row;
    rt     = drop_row[pk_way].recency;
    if (!ev_hit) begin
      for (int w = 0; w < flt_pkg::WAYS; w++) begin
        if (drop_row[w].valid) begin
          pk_row[w].recency = drop_row[w].recency + flt_pkg::rank_t'(1);
        end
      end
      pk_row[pk_way].valid      = 1'b1;
      pk_row[pk_way].src_addr   = sa_q;
      pk_row[pk_way].dst_addr   = da_q;
      pk_row[pk_way].ports      = {sp_q, dp_q};
      pk_row[pk_way].proto      = proto_q;
      pk_row[pk_way].reset_seen = 1'b0;
      pk_row[pk_way].last_fwd   = '0;
      pk_row[pk_way].last_rev   = '0;
      pk_row[pk_way].recency    = '0;
    end else begin
      for (int w = 0; w < flt_pkg::WAYS; w++) begin
        if (flt_pkg::way_t'(w) != pk_way && drop_row[w].valid && drop_row[w].recency < rt) begin
          pk_row[w].recency = drop_row[w].recency + flt_pkg::rank_t'(1);
        end
      end
      pk_row[pk_way].recency = '0;
    end
    pk_dir = !((pk_row[pk_way].src_addr == sa_q) && (pk_row[pk_way].ports[31:16] == sp_q));
    if (pk_dir) begin
      pk_row[pk_way].last_rev = now_q;
    end else begin
      pk_row[pk_way].last_fwd = now_q;
    end
    if (rstf_q) begin
      pk_row[pk_way].reset_seen = 1'b1;
    end
  end

  // Idle expiry of one bucket, with surviving ways ranked again.
  logic [flt_pkg::WAYS-1:0] sw_exp;
  flt_pkg::row_t            sw_row;
  flt_pkg::nway_t           sw_n;

  always_comb begin
    logic [31:0]    newest;
    logic [31:0]    age;
    flt_pkg::rank_t nr;
    sw_n = '0;
    for (int w = 0; w < flt_pkg::WAYS; w++) begin
      newest    = (rd_row[w].last_fwd > rd_row[w].last_rev) ? rd_row[w].last_fwd :
                  rd_row[w].last_rev;
      age       = now_q - newest;
      sw_exp[w] = rd_row[w].valid && (age > 32'(idle_timeout));
      sw_n      = sw_n + flt_pkg::nway_t'(sw_exp[w]);
    end
    sw_row = rd_row;
    for (int w = 0; w < flt_pkg::WAYS; w++) begin
      nr = '0;
      for (int v = 0; v < flt_pkg::WAYS; v++) begin
        if (rd_row[v].valid && !sw_exp[v] && rd_row[v].recency < rd_row[w].recency) begin
          nr = nr + flt_pkg::rank_t'(1);
        end
      end
      if (sw_exp[w]) begin
        sw_row[w].valid = 1'b0;
      end else if (rd_row[w].valid) begin
        sw_row[w].recency = nr;
      end
    end
  end

  // Memory port selection.
  always_comb begin
    ram_re    = cmd.del_rd || cmd.pk_rd || cmd.sw_rd;
    ram_raddr = walk_idx;
    if (cmd.del_rd) begin
      ram_raddr = del_slot[flt_pkg::SLOT_W-1:flt_pkg::WAY_W];
    end else if (cmd.pk_rd) begin
      ram_raddr = bucket_q;
    end
    ram_we    = 1'b0;
    ram_waddr = walk_idx;
    ram_wrow  = '0;
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.del_wr) begin
      ram_we    = del_hit;
      ram_waddr = del_slot[flt_pkg::SLOT_W-1:flt_pkg::WAY_W];
      ram_wrow  = del_row;
    end else if (cmd.pk_wr) begin
      ram_we    = !ev_refuse || ev_recreate;
      ram_waddr = bucket_q;
      ram_wrow  = ev_refuse ? drop_row : pk_row;
    end else if (cmd.sw_wr) begin
      ram_we   = 1'b1;
      ram_wrow = sw_row;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_flows      <= flt_pkg::RESET_MAX_FLOWS;
      idle_timeout   <= flt_pkg::RESET_IDLE;
      sweep_interval <= flt_pkg::RESET_SWEEP;
    end else if (cfg_we) begin
      case (cfg_index)
        flt_pkg::REG_MAX_FLOWS:      max_flows      <= cfg_data;
        flt_pkg::REG_IDLE_TIMEOUT:   idle_timeout   <= cfg_data[7:0];
        flt_pkg::REG_SWEEP_INTERVAL: sweep_interval <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Item capture, lookup results and result beat fields.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q        <= flt_pkg::opcode_t'(opcode);
      bucket_q    <= flt_pkg::bucket_t'(bucket_index);
      sa_q        <= src_addr;
      da_q        <= dst_addr;
      sp_q        <= src_port;
      dp_q        <= dst_port;
      proto_q     <= protocol;
      syn_q       <= syn;
      rstf_q      <= rst_req;
      now_q       <= now_seconds;
      res_status  <= flt_pkg::RES_DELETED;
      res_dir     <= 1'b0;
      res_expired <= '0;
      if (flt_pkg::opcode_t'(opcode) == flt_pkg::OP_DEFER ||
          flt_pkg::opcode_t'(opcode) == flt_pkg::OP_DEL_NOW) begin
        res_slot <= flt_pkg::slot_t'(slot);
      end else begin
        res_slot <= '0;
      end
      if (flt_pkg::opcode_t'(opcode) == flt_pkg::OP_PKT) begin
        del_slot <= pend_slot;
      end else begin
        del_slot <= flt_pkg::slot_t'(slot);
      end
    end
    if (cmd.pk_ev) begin
      ev_hit      <= m_hit_eff;
      ev_recreate <= m_recreate;
      ev_refuse   <= m_refuse;
      ev_found    <= m_found;
      ev_free     <= m_free;
      row_q       <= rd_row;
    end
    if (cmd.pk_wr) begin
      if (ev_refuse) begin
        res_status <= flt_pkg::RES_REFUSED;
        res_slot   <= '0;
        res_dir    <= 1'b0;
      end else begin
        res_status <= ev_hit ? flt_pkg::RES_FOUND : flt_pkg::RES_CREATED;
        res_slot   <= {bucket_q, pk_way};
        res_dir    <= pk_dir;
      end
    end
    if (cmd.sw_wr) begin
      res_expired <= res_expired + flt_pkg::cnt_t'(sw_n);
    end
  end

  // Table-wide control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
      last_sweep   <= '0;
      pend_valid   <= 1'b0;
      pend_slot    <= '0;
      walk_idx     <= '0;
    end else begin
      if (cmd.load) begin
        if (flt_pkg::opcode_t'(opcode) == flt_pkg::OP_DEFER) begin
          pend_valid <= 1'b1;
          pend_slot  <= flt_pkg::slot_t'(slot);
        end else if (flt_pkg::opcode_t'(opcode) == flt_pkg::OP_PKT) begin
          pend_valid <= 1'b0;
        end
      end
      if (cmd.clr_wr || cmd.sw_wr) begin
        walk_idx <= walk_idx + flt_pkg::bucket_t'(1);
      end else if (cmd.pk_wr) begin
        walk_idx <= '0;
      end
      if (cmd.del_wr && del_hit) begin
        active_count <= active_count - flt_pkg::cnt_t'(1);
        if (pend_valid && pend_slot == del_slot) begin
          pend_valid <= 1'b0;
        end
      end else if (cmd.pk_wr) begin
        if (ev_refuse || ev_hit) begin
          active_count <= active_count - flt_pkg::cnt_t'(ev_recreate);
        end else if (!ev_recreate) begin
          active_count <= active_count + flt_pkg::cnt_t'(1);
        end
      end else if (cmd.sw_wr) begin
        active_count <= active_count - flt_pkg::cnt_t'(sw_n);
        if (walk_idx == flt_pkg::bucket_t'(flt_pkg::BUCKETS - 1)) begin
          last_sweep <= now_q;
        end
      end
    end
  end

  assign sts.op         = op_q;
  assign sts.pend_valid = pend_valid;
  assign sts.walk_last  = (walk_idx == flt_pkg::bucket_t'(flt_pkg::BUCKETS - 1));
  assign sts.sweep_due  = ((now_q - last_sweep) >= 32'(sweep_interval));
  assign sts.refuse     = ev_refuse;

  assign status        = res_status;
  assign flow_slot     = 12'(res_slot);
  assign direction     = res_dir;
  assign expired_count = res_expired;

  // The live flow count can never exceed the number of slots.
  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    active_count <= flt_pkg::cnt_t'(flt_pkg::SLOTS))
    else $error("active flow count beyond table size");

  // A plain refusal leaves the bucket untouched.
  a_refuse_no_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.pk_wr && ev_refuse && !ev_recreate) |-> !ram_we)
    else $error("bucket written on a refused item");

  // A bucket cannot expire more flows than it has ways.
  a_expire_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.sw_wr |-> (sw_n <= flt_pkg::nway_t'(flt_pkg::WAYS)))
    else $error("more expiries than ways in a bucket");

endmodule

>>> bench/flow_table_lookup_insert_tb.sv
module flow_table_lookup_insert_tb;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int POOL_N      = 24;

  // One packet or delete request, and the beat it should produce.
  typedef struct {
    flt_pkg::opcode_t op;
    bit [9:0]    bkt;
    bit [31:0]   sa;
    bit [31:0]   da;
    bit [15:0]   sp;
    bit [15:0]   dp;
    bit [7:0]    proto;
    bit          syn;
    bit          rsq;
    bit [31:0]   now;
    bit [11:0]   slot;
  } pkt_item_t;

  typedef struct {
    flt_pkg::result_t st;
    bit [11:0]   fslot;
    bit          dir;
    bit [12:0]   nexp;
  } flow_res_t;

  typedef struct {
    pkt_item_t   it;
    bit          chk;
    flow_res_t   want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [9:0]  bucket_index;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  protocol;
  logic        syn;
  logic        rst_req;
  logic [31:0] now_seconds;
  logic [11:0] slot;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        done;
  logic [1:0]  status;
  logic [11:0] flow_slot;
  logic        direction;
  logic [12:0] expired_count;

  flow_table_lookup_insert dut (.*);

  // Shadow copy of the flow table.
  bit          tbl_valid [flt_pkg::SLOTS];
  bit [31:0]   tbl_src   [flt_pkg::SLOTS];
  bit [31:0]   tbl_dst   [flt_pkg::SLOTS];
  bit [31:0]   tbl_ports [flt_pkg::SLOTS];
  bit [7:0]    tbl_proto [flt_pkg::SLOTS];
  bit          tbl_rs    [flt_pkg::SLOTS];
  bit [31:0]   tbl_fwd   [flt_pkg::SLOTS];
  bit [31:0]   tbl_rev   [flt_pkg::SLOTS];
  int unsigned tbl_rank  [flt_pkg::SLOTS];
  int unsigned live_flows;
  bit [31:0]   last_sweep_t;
  bit          pend_v;
  bit [11:0]   pend_s;
  bit [12:0]   cap_max;
  bit [7:0]    idle_lim;
  bit [7:0]    sweep_gap;

  flow_res_t   pending_beats[$];
  bit          failed;
  int unsigned cycles;

  // Stimulus pool of flows, so that lookups hit and buckets fill.
  bit [9:0]    pool_bkt   [POOL_N];
  bit [31:0]   pool_sa    [POOL_N];
  bit [31:0]   pool_da    [POOL_N];
  bit [15:0]   pool_sp    [POOL_N];
  bit [15:0]   pool_dp    [POOL_N];
  bit [7:0]    pool_proto [POOL_N];
  bit [31:0]   clock_secs;

  // Register settings and lengths of the random phases.
  int          ph_max   [6] = '{8191, 0, 1, 4096, 6, 4096};
  int          ph_idle  [6] = '{255, 30, 0, 20, 255, 0};
  int          ph_sweep [6] = '{255, 1, 0, 40, 255, 255};
  int          ph_count [6] = '{500, 40, 20, 500, 300, 290};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Removes a flow and closes up the ranks of its bucket.
  function automatic void drop_flow(int unsigned s);
    int unsigned b;
    int unsigned r;
    if (!tbl_valid[s]) return;
    b = (s / flt_pkg::WAYS) * flt_pkg::WAYS;
    r = tbl_rank[s];
    tbl_valid[s] = 1'b0;
    for (int w = 0; w < flt_pkg::WAYS; w++)
      if (tbl_valid[b + w] && tbl_rank[b + w] > r) tbl_rank[b + w]--;
    if (live_flows > 0) live_flows--;
    if (pend_v && pend_s == s) pend_v = 1'b0;
  endfunction

  // Works out the beat for one accepted item and updates the shadow table.
  function automatic flow_res_t flow_lookup(pkt_item_t it);
    flow_res_t   res;
    int unsigned b;
    int unsigned s;
    int unsigned found;
    int unsigned free_way;
    int unsigned r;
    int unsigned nexp;
    bit          hit;
    bit          has_free;
    bit [31:0]   newest;
    res = '{flt_pkg::RES_DELETED, 12'd0, 1'b0, 13'd0};
    b = it.bkt * flt_pkg::WAYS;
    found = 0;
    free_way = 0;
    hit = 0;
    has_free = 0;
    nexp = 0;
    case (it.op)
      flt_pkg::OP_DEFER: begin
        pend_v = 1'b1;
        pend_s = it.slot;
        res.fslot = it.slot;
        return res;
      end
      flt_pkg::OP_DEL_NOW: begin
        drop_flow(it.slot);
        res.fslot = it.slot;
        return res;
      end
      flt_pkg::OP_RSVD: return res;
      default: ;
    endcase
    if (pend_v) begin
      pend_v = 1'b0;
      drop_flow(pend_s);
    end
    // Search the bucket in both directions; the most recent match wins.
    for (int w = 0; w < flt_pkg::WAYS; w++) begin
      s = b + w;
      if (!tbl_valid[s]) begin
        if (!has_free) begin
          has_free = 1;
          free_way = s;
        end
        continue;
      end
      if (tbl_proto[s] != it.proto) continue;
      if ((tbl_src[s] == it.sa && tbl_dst[s] == it.da && tbl_ports[s] == {it.sp, it.dp}) ||
          (tbl_src[s] == it.da && tbl_dst[s] == it.sa && tbl_ports[s] == {it.dp, it.sp}))
        if (!hit || tbl_rank[s] < tbl_rank[found]) begin
          hit = 1;
          found = s;
        end
    end
    // A SYN on a TCP flow that has seen RST starts the flow afresh.
    if (hit && it.proto == flt_pkg::PROTO_TCP && tbl_rs[found] && it.syn) begin
      drop_flow(found);
      hit = 0;
      if (!has_free) begin
        has_free = 1;
        free_way = found;
      end else if (found < free_way) begin
        free_way = found;
      end
    end
    if (!hit) begin
      if (live_flows >= cap_max || !has_free) begin
        res.st = flt_pkg::RES_REFUSED;
        return res;
      end
      s = free_way;
      for (int w = 0; w < flt_pkg::WAYS; w++)
        if (tbl_valid[b + w]) tbl_rank[b + w]++;
      tbl_valid[s] = 1'b1;
      tbl_rank[s] = 0;
      tbl_src[s] = it.sa;
      tbl_dst[s] = it.da;
      tbl_ports[s] = {it.sp, it.dp};
      tbl_proto[s] = it.proto;
      tbl_rs[s] = 1'b0;
      tbl_fwd[s] = 0;
      tbl_rev[s] = 0;
      live_flows++;
      res.st = flt_pkg::RES_CREATED;
    end else begin
      s = found;
      r = tbl_rank[s];
      for (int w = 0; w < flt_pkg::WAYS; w++)
        if (b + w != s && tbl_valid[b + w] && tbl_rank[b + w] < r) tbl_rank[b + w]++;
      tbl_rank[s] = 0;
      res.st = flt_pkg::RES_FOUND;
    end
    res.dir = !(tbl_src[s] == it.sa && tbl_ports[s][31:16] == it.sp);
    if (res.dir) tbl_rev[s] = it.now;
    else tbl_fwd[s] = it.now;
    if (it.rsq) tbl_rs[s] = 1'b1;
    // Idle expiry over the whole table.
    if (it.now - last_sweep_t >= sweep_gap) begin
      for (int unsigned t = 0; t < flt_pkg::SLOTS; t++) begin
        if (!tbl_valid[t]) continue;
        newest = (tbl_fwd[t] > tbl_rev[t]) ? tbl_fwd[t] : tbl_rev[t];
        if (it.now - newest > idle_lim) begin
          drop_flow(t);
          nexp++;
        end
      end
      last_sweep_t = it.now;
    end
    res.fslot = 12'(s);
    res.nexp = 13'(nexp);
    return res;
  endfunction

  function automatic dir_row_t row(flt_pkg::opcode_t op, bit [9:0] bkt, bit [31:0] sa,
                                   bit [31:0] da, bit [15:0] sp, bit [15:0] dp,
                                   bit [7:0] proto, bit sy, bit rq, bit [31:0] now,
                                   bit [11:0] sl, bit chk, flt_pkg::result_t st,
                                   bit [11:0] fs, bit dr);
    dir_row_t d;
    d.it = '{op, bkt, sa, da, sp, dp, proto, sy, rq, now, sl};
    d.chk = chk;
    d.want = '{st, fs, dr, 13'd0};
    return d;
  endfunction

  // Random item: mostly pool flows in either direction, some deletes, some noise.
  function automatic pkt_item_t random_item();
    pkt_item_t   it;
    int unsigned k;
    int unsigned pick;
    k = $urandom_range(0, 99);
    pick = $urandom_range(0, POOL_N - 1);
    if ($urandom_range(0, 99) == 0) clock_secs = $urandom;
    else clock_secs += $urandom_range(0, 1);
    it.op    = flt_pkg::OP_PKT;
    it.bkt   = 10'($urandom);
    it.sa    = $urandom;
    it.da    = $urandom;
    it.sp    = 16'($urandom);
    it.dp    = 16'($urandom);
    it.proto = 8'($urandom);
    it.syn   = 1'($urandom);
    it.rsq   = 1'($urandom);
    it.now   = clock_secs;
    it.slot  = 12'($urandom);
    if (k < 80) begin
      it.bkt = pool_bkt[pick];
      it.proto = pool_proto[pick];
      if ($urandom_range(0, 1)) begin
        it.sa = pool_sa[pick];
        it.da = pool_da[pick];
        it.sp = pool_sp[pick];
        it.dp = pool_dp[pick];
      end else begin
        it.sa = pool_da[pick];
        it.da = pool_sa[pick];
        it.sp = pool_dp[pick];
        it.dp = pool_sp[pick];
      end
      it.syn = ($urandom_range(0, 4) == 0);
      it.rsq = ($urandom_range(0, 6) == 0);
    end else if (k < 94) begin
      it.op = $urandom_range(0, 1) ? flt_pkg::OP_DEFER : flt_pkg::OP_DEL_NOW;
      if ($urandom_range(0, 3) != 0)
        it.slot = 12'(pool_bkt[pick] * flt_pkg::WAYS + $urandom_range(0, flt_pkg::WAYS - 1));
    end else if (k < 96) begin
      it.op = flt_pkg::OP_RSVD;
    end
    return it;
  endfunction

  // Offers one item and waits for the block to take it.
  task automatic send_item(pkt_item_t it, bit may_idle, bit chk, flow_res_t want);
    flow_res_t got;
    if (may_idle && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start        <= 1'b1;
    opcode       <= it.op;
    bucket_index <= it.bkt;
    src_addr     <= it.sa;
    dst_addr     <= it.da;
    src_port     <= it.sp;
    dst_port     <= it.dp;
    protocol     <= it.proto;
    syn          <= it.syn;
    rst_req      <= it.rsq;
    now_seconds  <= it.now;
    slot         <= it.slot;
    do @(posedge clk); while (busy);
    got = flow_lookup(it);
    pending_beats.push_back(chk ? want : got);
  endtask

  // Withdraws the last item at its accepting edge, then waits for the block to settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      flt_pkg::REG_MAX_FLOWS:      cap_max = val;
      flt_pkg::REG_IDLE_TIMEOUT:   idle_lim = val[7:0];
      flt_pkg::REG_SWEEP_INTERVAL: sweep_gap = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Checks every result beat against the oldest expectation.
  always @(posedge clk) begin
    flow_res_t e;
    if (!rst && done) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1'b1;
      end else begin
        e = pending_beats.pop_front();
        if (status !== e.st) begin
          $error("status expected %0d got %0d", e.st, status);
          failed = 1'b1;
        end
        if (flow_slot !== e.fslot) begin
          $error("flow_slot expected %0d got %0d", e.fslot, flow_slot);
          failed = 1'b1;
        end
        if (direction !== e.dir) begin
          $error("direction expected %0d got %0d", e.dir, direction);
          failed = 1'b1;
        end
        if (expired_count !== e.nexp) begin
          $error("expired_count expected %0d got %0d", e.nexp, expired_count);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows[$];
    flow_res_t   none;
    int unsigned n_items;
    clk = 1'b0;
    cycles = 0;
    failed = 1'b0;
    none = '{flt_pkg::RES_FOUND, 12'd0, 1'b0, 13'd0};
    start <= 1'b0;
    opcode <= '0;
    bucket_index <= '0;
    src_addr <= '0;
    dst_addr <= '0;
    src_port <= '0;
    dst_port <= '0;
    protocol <= '0;
    syn <= 1'b0;
    rst_req <= 1'b0;
    now_seconds <= '0;
    slot <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rst <= 1'b1;

    // Shadow state after reset.
    for (int i = 0; i < flt_pkg::SLOTS; i++) tbl_valid[i] = 1'b0;
    live_flows = 0;
    last_sweep_t = 0;
    pend_v = 1'b0;
    pend_s = 0;
    cap_max = flt_pkg::RESET_MAX_FLOWS;
    idle_lim = flt_pkg::RESET_IDLE;
    sweep_gap = flt_pkg::RESET_SWEEP;

    for (int i = 0; i < POOL_N; i++) begin
      pool_bkt[i] = (i < 4) ? 10'd0 : (i < 8) ? 10'd1023 : 10'($urandom_range(1, 4) * 97);
      pool_sa[i] = $urandom;
      pool_da[i] = $urandom;
      pool_sp[i] = 16'($urandom);
      pool_dp[i] = 16'($urandom);
      pool_proto[i] = $urandom_range(0, 1) ? flt_pkg::PROTO_TCP : 8'd17;
    end
    pool_sp[1] = 16'hffff;
    pool_da[2] = 32'hffffffff;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: creation, reverse hit, RST then SYN, full bucket, deletes, extremes.
    rows.push_back(row(flt_pkg::OP_PKT, 5, 32'h0a000001, 32'h0a000002, 1234, 80,
                       flt_pkg::PROTO_TCP, 0, 0, 100, 0, 1, flt_pkg::RES_CREATED, 20, 0));
    rows.push_back(row(flt_pkg::OP_PKT, 5, 32'h0a000002, 32'h0a000001, 80, 1234,
                       flt_pkg::PROTO_TCP, 0, 0, 100, 0, 1, flt_pkg::RES_FOUND, 20, 1));
    rows.push_back(row(flt_pkg::OP_PKT, 5, 32'h0a000002, 32'h0a000001, 80, 1234,
                       flt_pkg::PROTO_TCP, 0, 1, 100, 0, 0, flt_pkg::RES_FOUND, 0, 0));
    rows.push_back(row(flt_pkg::OP_PKT, 5, 32'h0a000001, 32'h0a000002, 1234, 80,
                       flt_pkg::PROTO_TCP, 1, 0, 100, 0, 0, flt_pkg::RES_FOUND, 0, 0));
    rows.push_back(row(flt_pkg::OP_PKT, 5, 32'h0a000001, 32'h0a000002, 1, 2, 17, 0, 0, 100,
                       0, 0, flt_pkg::RES_FOUND, 0, 0));
    rows.push_back(row(flt_pkg::OP_PKT, 5, 32'h0a000001, 32'h0a000002, 3, 4, 17, 0, 0, 100,
                       0, 0, flt_pkg::RES_FOUND, 0, 0));
    rows.push_back(row(flt_pkg::OP_PKT, 5, 32'h0a000001, 32'h0a000002, 5, 6, 17, 0, 0, 100,
                       0, 0, flt_pkg::RES_FOUND, 0, 0));
    rows.push_back(row(flt_pkg::OP_PKT, 5, 32'h0a000001, 32'h0a000002, 7, 8, 17, 0, 0, 100,
                       0, 1, flt_pkg::RES_REFUSED, 0, 0));
    rows.push_back(row(flt_pkg::OP_DEFER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 21, 1,
                       flt_pkg::RES_DELETED, 21, 0));
    rows.push_back(row(flt_pkg::OP_PKT, 5, 32'h0a000001, 32'h0a000002, 9, 10, 17, 0, 0, 100,
                       0, 0, flt_pkg::RES_FOUND, 0, 0));
    rows.push_back(row(flt_pkg::OP_DEFER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 22, 1,
                       flt_pkg::RES_DELETED, 22, 0));
    rows.push_back(row(flt_pkg::OP_DEL_NOW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 22, 1,
                       flt_pkg::RES_DELETED, 22, 0));
    rows.push_back(row(flt_pkg::OP_PKT, 5, 32'h0a000001, 32'h0a000002, 11, 12, 17, 0, 0, 100,
                       0, 0, flt_pkg::RES_FOUND, 0, 0));
    rows.push_back(row(flt_pkg::OP_DEL_NOW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4095, 1,
                       flt_pkg::RES_DELETED, 4095, 0));
    rows.push_back(row(flt_pkg::OP_RSVD, 7, 1, 2, 3, 4, 5, 1, 1, 100, 77, 1,
                       flt_pkg::RES_DELETED, 0, 0));
    rows.push_back(row(flt_pkg::OP_DEL_NOW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 20, 1,
                       flt_pkg::RES_DELETED, 20, 0));
    rows.push_back(row(flt_pkg::OP_PKT, 1023, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff,
                       8'hff, 1, 1, 32'hffffffff, 12'hfff, 0, flt_pkg::RES_FOUND, 0, 0));
    rows.push_back(row(flt_pkg::OP_PKT, 0, 0, 0, 0, 0, flt_pkg::PROTO_TCP, 0, 1, 0, 0, 0,
                       flt_pkg::RES_FOUND, 0, 0));
    rows.push_back(row(flt_pkg::OP_PKT, 0, 0, 0, 0, 0, flt_pkg::PROTO_TCP, 1, 0, 0, 0, 0,
                       flt_pkg::RES_FOUND, 0, 0));
    foreach (rows[i]) send_item(rows[i].it, 1'b1, rows[i].chk, rows[i].want);
    clock_secs = 0;

    // Random phases, each under its own register setting.
    n_items = 0;
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      cfg_write(flt_pkg::REG_MAX_FLOWS, 13'(ph_max[p]));
      cfg_write(flt_pkg::REG_IDLE_TIMEOUT, 13'(ph_idle[p]));
      cfg_write(flt_pkg::REG_SWEEP_INTERVAL, 13'(ph_sweep[p]));
      for (int i = 0; i < ph_count[p]; i++) begin
        send_item(random_item(), !(n_items >= 700 && n_items < 1000), 1'b0, none);
        n_items++;
      end
    end

    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
